@@ hdl/nrtp_pkg.sv @@
`timescale 1ns / 1ps

package nrtp_pkg;

    // Field widths fixed by the item formats
    localparam int OP_W       = 2;
    localparam int CTX_FIELD_W = 4;
    localparam int REG_FIELD_W = 6;
    localparam int TIME_W     = 32;
    localparam int TOTAL_W    = 48;
    localparam int COUNT_W    = 32;
    localparam int STATUS_W   = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_END   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]        operation;
        logic [CTX_FIELD_W-1:0] context_req;
        logic [REG_FIELD_W-1:0] region;
        logic [TIME_W-1:0]      timestamp;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [REG_FIELD_W-1:0] region_out;
        logic [TIME_W-1:0]      elapsed;
        logic [TIME_W-1:0]      max_elapsed;
        logic [TIME_W-1:0]      min_elapsed;
        logic [TOTAL_W-1:0]     total_elapsed;
        logic [COUNT_W-1:0]     call_count;
        logic [TIME_W-1:0]      average_elapsed;
    } rsp_item_t;

    // One region's statistics record, as held in the statistics memory
    typedef struct packed {
        logic [TIME_W-1:0]  last;
        logic [TIME_W-1:0]  max;
        logic [TIME_W-1:0]  min;
        logic [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0] calls;
    } stats_t;

    localparam stats_t STATS_RESET = '{
        last:  '0,
        max:   '0,
        min:   '1,
        total: '0,
        calls: '0
    };

endpackage

@@ hdl/nrtp_ram.sv @@
`timescale 1ns / 1ps

module nrtp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                           clk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/nrtp_div.sv @@
`timescale 1ns / 1ps

module nrtp_div
    import nrtp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [TOTAL_W-1:0] dividend,
    input  logic [COUNT_W-1:0] divisor,
    output logic               done,
    output logic [TIME_W-1:0]  quotient
);

    localparam int HI_W  = TOTAL_W - COUNT_W;
    localparam int CNT_W = $clog2(COUNT_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] quo_reg, quo_next;
    logic [COUNT_W-1:0] dvs_reg, dvs_next;

    logic [COUNT_W:0]   shifted;
    logic [COUNT_W:0]   diff;
    logic               fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, quo_reg[COUNT_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;

        if (start)
        begin
            dvs_next = divisor;
            if (divisor == '0)
            begin
                // no calls yet: average reads zero
                quo_next  = '0;
                done_next = 1'b1;
            end
            else if ({{(COUNT_W - HI_W){1'b0}}, dividend[TOTAL_W-1:COUNT_W]} >= divisor)
            begin
                // quotient would not fit in 32 bits
                quo_next  = '1;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = COUNT_W'(dividend[TOTAL_W-1:COUNT_W]);
                quo_next  = dividend[COUNT_W-1:0];
                cnt_next  = CNT_W'(COUNT_W);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the top bit is always clear
            rem_next = fits ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
            quo_next = {quo_reg[COUNT_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/nested_region_time_profiler_core.sv @@
`timescale 1ns / 1ps

// Nested region time profiler.
// Request channel (req_valid / req_stall / req): start pushes a region and
// its timestamp on the context's stack, end pops it and folds the elapsed
// time into the region's statistics, read reports a region's statistics.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one item per request,
// in request order. Status flags a full stack on start or an empty one on end.
// One request is worked on at a time. Start, read and end all pass through
// the 32-step restoring divider for the average; for a region with no calls it
// returns zero without stepping, and an end on an empty stack skips the
// statistics memory and the divider.
// Stack levels, stack entries and region statistics sit in three simple
// dual-port synchronous RAMs with registered read ports.
// After reset the block sweeps the level and statistics memories to their
// initial values, one entry a cycle; req_stall stays high until the sweep
// is done.
// The response is held in an output register: while it is valid and rsp_stall
// is high it does not change, and the next request is still taken and worked on up to
// the point where its response is ready.
module nested_region_time_profiler_core
    import nrtp_pkg::*;
#(
    parameter int CONTEXT_COUNT = 16,
    parameter int REGION_COUNT  = 64,
    parameter int STACK_DEPTH   = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int CW     = (CONTEXT_COUNT > 1) ? $clog2(CONTEXT_COUNT) : 1;
    localparam int RW     = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
    localparam int SLOTS  = CONTEXT_COUNT * STACK_DEPTH;
    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW     = $clog2(STACK_DEPTH + 1);
    localparam int CLR_N  = (CONTEXT_COUNT > REGION_COUNT) ? CONTEXT_COUNT : REGION_COUNT;
    localparam int CLW    = $clog2(CLR_N + 1);
    localparam int CTX_N  = 2 ** CTX_FIELD_W;
    localparam int REG_N  = 2 ** REG_FIELD_W;
    localparam int STK_W  = RW + TIME_W;

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LEVEL = 3'd2;
    localparam logic [2:0] S_STACK = 3'd3;
    localparam logic [2:0] S_STAT  = 3'd4;
    localparam logic [2:0] S_DIVGO = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    // Control
    logic [2:0]      state_reg, state_next;
    logic [CLW-1:0]  clr_reg, clr_next;
    logic            rsp_valid_reg, rsp_valid_next;

    // Item being worked on
    logic [OP_W-1:0]     op_reg, op_next;
    logic [CW-1:0]       ctx_reg, ctx_next;
    logic [RW-1:0]       reg_reg, reg_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [SW-1:0]       base_reg, base_next;
    logic [TIME_W-1:0]   el_reg, el_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    stats_t              cur_reg, cur_next;
    logic [TIME_W-1:0]   avg_reg, avg_next;
    rsp_item_t           rsp_reg, rsp_next;

    // Modulo tables for out-of-range context and region numbers
    logic [CW-1:0] ctx_tab [CTX_N];
    logic [RW-1:0] reg_tab [REG_N];
    logic [CW-1:0] ctx_red;
    logic [RW-1:0] reg_red;

    // Memory ports
    logic          lvl_we;
    logic [CW-1:0] lvl_waddr, lvl_raddr;
    logic [LW-1:0] lvl_wdata, lvl_rdata;

    logic             stk_we;
    logic [SW-1:0]    stk_waddr, stk_raddr;
    logic [STK_W-1:0] stk_wdata, stk_rdata;
    logic [RW-1:0]    stk_region;

    logic          st_we;
    logic [RW-1:0] st_waddr, st_raddr;
    stats_t        st_wdata, st_rdata;
    stats_t        stat_upd;
    logic [TOTAL_W:0] sum;

    logic              div_start;
    logic              div_done;
    logic [TIME_W-1:0] div_quo;

    genvar g;
    for (g = 0; g < CTX_N; g++)
    begin : g_ctx_tab
        assign ctx_tab[g] = CW'(g % CONTEXT_COUNT);
    end
    for (g = 0; g < REG_N; g++)
    begin : g_reg_tab
        assign reg_tab[g] = RW'(g % REGION_COUNT);
    end

    assign ctx_red = ctx_tab[req.context_req];
    assign reg_red = reg_tab[req.region];

    // Per-context stack level
    nrtp_ram #(
        .WIDTH (LW),
        .DEPTH (CONTEXT_COUNT)
    ) u_level_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (lvl_wdata),
        .raddr (lvl_raddr),
        .rdata (lvl_rdata)
    );

    // Stack entries: region and start time
    nrtp_ram #(
        .WIDTH (STK_W),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Per-region statistics
    nrtp_ram #(
        .WIDTH ($bits(stats_t)),
        .DEPTH (REGION_COUNT)
    ) u_stats_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Average = total / calls
    nrtp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cur_reg.total),
        .divisor  (cur_reg.calls),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign stk_region = stk_rdata[STK_W-1:TIME_W];
    assign lvl_raddr  = (state_reg == S_IDLE) ? ctx_red : ctx_reg;
    assign st_raddr   = (state_reg == S_STACK) ? stk_region : reg_reg;
    assign stk_raddr  = base_reg + SW'(lvl_rdata) - SW'(1);
    assign stk_waddr  = base_reg + SW'(lvl_rdata);
    assign stk_wdata  = {reg_reg, now_reg};

    // Statistics update for a completed region
    assign sum = {1'b0, st_rdata.total} + (TOTAL_W + 1)'(el_reg);

    always_comb
    begin
        stat_upd.last  = el_reg;
        stat_upd.max   = (el_reg > st_rdata.max) ? el_reg : st_rdata.max;
        stat_upd.min   = (el_reg < st_rdata.min) ? el_reg : st_rdata.min;
        stat_upd.total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        stat_upd.calls = (st_rdata.calls == '1) ? st_rdata.calls
                                                : st_rdata.calls + COUNT_W'(1);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        rsp_valid_next = rsp_valid_reg & rsp_stall;
        op_next        = op_reg;
        ctx_next       = ctx_reg;
        reg_next       = reg_reg;
        now_next       = now_reg;
        base_next      = base_reg;
        el_next        = el_reg;
        status_next    = status_reg;
        cur_next       = cur_reg;
        avg_next       = avg_reg;
        rsp_next       = rsp_reg;

        lvl_we    = 1'b0;
        lvl_waddr = ctx_reg;
        lvl_wdata = '0;
        stk_we    = 1'b0;
        st_we     = 1'b0;
        st_waddr  = reg_reg;
        st_wdata  = stat_upd;
        div_start = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                lvl_we    = clr_reg < CLW'(CONTEXT_COUNT);
                lvl_waddr = clr_reg[CW-1:0];
                st_we     = clr_reg < CLW'(REGION_COUNT);
                st_waddr  = clr_reg[RW-1:0];
                st_wdata  = STATS_RESET;
                clr_next  = clr_reg + CLW'(1);
                if (clr_reg == CLW'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.operation;
                    ctx_next   = ctx_red;
                    reg_next   = reg_red;
                    now_next   = req.timestamp;
                    base_next  = SW'(ctx_red * STACK_DEPTH);
                    state_next = S_LEVEL;
                end
            end

            S_LEVEL:
            begin
                status_next = ST_OK;
                case (op_reg)
                    OP_START:
                    begin
                        if (lvl_rdata == LW'(STACK_DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            stk_we    = 1'b1;
                            lvl_we    = 1'b1;
                            lvl_wdata = lvl_rdata + LW'(1);
                        end
                        state_next = S_STAT;
                    end
                    OP_END:
                    begin
                        if (lvl_rdata == '0)
                        begin
                            // empty stack: report with every field but the status zero
                            status_next = ST_EMPTY;
                            reg_next    = '0;
                            cur_next    = '0;
                            avg_next    = '0;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            lvl_we     = 1'b1;
                            lvl_wdata  = lvl_rdata - LW'(1);
                            state_next = S_STACK;
                        end
                    end
                    default:
                    begin
                        state_next = S_STAT;
                    end
                endcase
            end

            S_STACK:
            begin
                // popped entry arrives; statistics of its region are fetched
                reg_next   = stk_region;
                el_next    = now_reg - stk_rdata[TIME_W-1:0];
                state_next = S_STAT;
            end

            S_STAT:
            begin
                if (op_reg == OP_END)
                begin
                    st_we    = 1'b1;
                    cur_next = stat_upd;
                end
                else
                begin
                    cur_next = st_rdata;
                end
                state_next = S_DIVGO;
            end

            S_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = div_quo;
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status          = status_reg;
                    rsp_next.region_out      = REG_FIELD_W'(reg_reg);
                    rsp_next.elapsed         = cur_reg.last;
                    rsp_next.max_elapsed     = cur_reg.max;
                    rsp_next.min_elapsed     = cur_reg.min;
                    rsp_next.total_elapsed   = cur_reg.total;
                    rsp_next.call_count      = cur_reg.calls;
                    rsp_next.average_elapsed = avg_reg;
                    rsp_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        ctx_reg    <= ctx_next;
        reg_reg    <= reg_next;
        now_reg    <= now_next;
        base_reg   <= base_next;
        el_reg     <= el_next;
        status_reg <= status_next;
        cur_reg    <= cur_next;
        avg_reg    <= avg_next;
        rsp_reg    <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
